/* src/binomial_coefficient_defines.svh */
// Assertion macros shared by the checker.
`ifndef BINOMIAL_COEFFICIENT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_DEFINES_SVH

// Antecedent holds now, consequent must hold in the next cycle.
`define BC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

// Implication with an explicit sequence on the right-hand side.
`define BC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
		else $error("%m: check failed");

`endif

/* src/binom_pkg.sv */
package binom_pkg;

	localparam int N_W    = 6;
	localparam int COEF_W = 32;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic init;
		logic row_begin;
		logic sweep;
		logic next_row;
		logic mir_rd;
		logic mir_wr;
		logic res_rd;
		logic out_load;
	} binom_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic zero;
		logic row_over;
		logic end_zero;
		logic col_one;
		logic mirror_en;
		logic out_free;
	} binom_sts_t;

endpackage

/* src/binom_if.sv */
interface binom_req_if import binom_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [N_W-1:0]   n_total;
	logic [N_W-1:0]   r_pick;

	modport source (output valid, output n_total, output r_pick, input ready);
	modport sink   (input valid, input n_total, input r_pick, output ready);
endinterface

interface binom_res_if import binom_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COEF_W-1:0] coefficient;

	modport source (output valid, output coefficient, input ready);
	modport sink   (input valid, input coefficient, output ready);
endinterface

/* src/binomial_coefficient.sv */
// Binomial coefficient C(n,r) by Pascal's triangle, wrapped to VALUE_WIDTH.
// operands: a valid/ready channel carrying n_total and r_pick; a transfer
//   takes place when valid and ready are both high. Ready is high only
//   while no request is in progress; one request is worked at a time.
// result: a valid/ready channel carrying coefficient, zero when r exceeds n.
// Timing: when r exceeds n, the request passes INIT and DONE and the result
//   register is loaded. Otherwise each row 1..n takes a row start, a sweep of
//   e column adds (e being min(r, row/2) with r folded), a drain step when e
//   is nonzero, and a read and a write for each mirror copy. The sweep runs
//   at one column add per cycle through the row memory's single write port.
// Next request: a new transfer can be taken in the cycle after a result is loaded.
// Reset: arst_n low clears the controller to idle and drops result valid;
//   the row memory is not cleared, each request seeds its first entry.
// Stall: a finished result sits in the output register until the receiver
//   takes it; a new request may be taken meanwhile, and its own result is
//   held back until the output register is free.
module binomial_coefficient import binom_pkg::*; #(
	parameter int MAX_N       = 63,
	parameter int VALUE_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	binom_req_if.sink    operands,
	binom_res_if.source  result
);

	binom_cmd_t cmd;
	binom_sts_t sts;

	// sequence rows and columns
	binom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operands.valid),
		.in_ready (operands.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the row memory, counters and output register
	binom_dp #(
		.MAX_N       (MAX_N),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.n_total     (operands.n_total),
		.r_pick      (operands.r_pick),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.coefficient (result.coefficient)
	);

endmodule

/* src/binom_ctrl.sv */
module binom_ctrl import binom_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  binom_sts_t sts,
	output binom_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INIT   = 4'd1;
	localparam logic [3:0] S_ROW    = 4'd2;
	localparam logic [3:0] S_SWEEP  = 4'd3;
	localparam logic [3:0] S_DRAIN  = 4'd4;
	localparam logic [3:0] S_MIR_RD = 4'd5;
	localparam logic [3:0] S_MIR_WR = 4'd6;
	localparam logic [3:0] S_RES_RD = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_INIT;
				end
			end
			S_INIT: begin
				if (sts.zero) begin
					state_d = S_DONE;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_ROW;
				end
			end
			S_ROW: begin
				if (sts.row_over) begin
					state_d = S_RES_RD;
				end else begin
					cmd.row_begin = 1'b1;
					if (!sts.end_zero) begin
						state_d = S_SWEEP;
					end else if (sts.mirror_en) begin
						state_d = S_MIR_RD;
					end else begin
						cmd.next_row = 1'b1;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.col_one) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last column write lands this cycle
				if (sts.mirror_en) begin
					state_d = S_MIR_RD;
				end else begin
					cmd.next_row = 1'b1;
					state_d      = S_ROW;
				end
			end
			S_MIR_RD: begin
				cmd.mir_rd = 1'b1;
				state_d    = S_MIR_WR;
			end
			S_MIR_WR: begin
				cmd.mir_wr   = 1'b1;
				cmd.next_row = 1'b1;
				state_d      = S_ROW;
			end
			S_RES_RD: begin
				cmd.res_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/binom_dp.sv */
module binom_dp import binom_pkg::*; #(
	parameter int MAX_N       = 63,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [N_W-1:0]    n_total,
	input  logic [N_W-1:0]    r_pick,
	input  binom_cmd_t        cmd,
	output binom_sts_t        sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [COEF_W-1:0] coefficient
);

	localparam int N_EFF = (MAX_N < 63) ? MAX_N : 63;
	localparam int DEPTH = N_EFF / 2 + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = (VALUE_WIDTH > COEF_W) ? VALUE_WIDTH : COEF_W;
	localparam logic [N_W-1:0] N_CAP = N_W'(N_EFF);

	logic [VALUE_WIDTH-1:0] mem_q [DEPTH];

	logic [N_W-1:0]         n_q;
	logic [N_W-1:0]         r_q;
	logic                   zero_q;
	logic [N_W:0]           row_q;
	logic [AW-1:0]          col_q;

	logic [VALUE_WIDTH-1:0] rd_a_q;
	logic [VALUE_WIDTH-1:0] rd_b_q;
	logic                   pend_s1;
	logic [AW-1:0]          waddr_s1;

	logic                   out_valid_q;
	logic [COEF_W-1:0]      coef_q;

	logic [N_W-1:0]         n_sat;
	logic [N_W-1:0]         mid;
	logic [N_W-1:0]         end_col;
	logic [VALUE_WIDTH-1:0] sum;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [VALUE_WIDTH-1:0] wdata;
	logic                   rd_a_en;
	logic [AW-1:0]          rd_a_addr;
	logic [EW-1:0]          rd_ext;

	assign n_sat   = (n_total > N_CAP) ? N_CAP : n_total;
	assign mid     = row_q[N_W:1];
	assign end_col = (r_q < mid) ? r_q : mid;
	assign sum     = rd_a_q + rd_b_q;
	assign rd_ext  = EW'(rd_a_q);

	assign sts.zero      = zero_q;
	assign sts.row_over  = (row_q > {1'b0, n_q});
	assign sts.end_zero  = (end_col == '0);
	assign sts.col_one   = (col_q == AW'(1));
	assign sts.mirror_en = (mid < r_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;

	// single write port: seed, column update, then mirror copy
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		if (cmd.init) begin
			we    = 1'b1;
			wdata = VALUE_WIDTH'(1);
		end else if (pend_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = sum;
		end else if (cmd.mir_wr) begin
			we    = 1'b1;
			waddr = AW'(mid + N_W'(1));
			wdata = rd_a_q;
		end
	end

	always_comb begin
		rd_a_en   = cmd.sweep || cmd.mir_rd || cmd.res_rd;
		rd_a_addr = col_q;
		if (cmd.mir_rd) begin
			rd_a_addr = AW'(mid);
		end else if (cmd.res_rd) begin
			rd_a_addr = AW'(r_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= mem_q[rd_a_addr];
		end
		if (cmd.sweep) begin
			rd_b_q <= mem_q[col_q - AW'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= n_sat;
			zero_q <= (r_pick > n_sat);
			r_q    <= (r_pick > (n_sat >> 1)) ? (n_sat - r_pick) : r_pick;
		end
		if (cmd.sweep) begin
			waddr_s1 <= col_q;
		end
		if (cmd.out_load) begin
			coef_q <= zero_q ? '0 : rd_ext[COEF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.sweep;
			if (cmd.init) begin
				row_q <= (N_W+1)'(1);
			end else if (cmd.next_row) begin
				row_q <= row_q + (N_W+1)'(1);
			end
			if (cmd.row_begin) begin
				col_q <= AW'(end_col);
			end else if (cmd.sweep) begin
				col_q <= col_q - AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/binom_chk.sv */
`include "binomial_coefficient_defines.svh"

module binom_chk import binom_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [COEF_W-1:0] coefficient
);

	// a stalled result stays offered
	`BC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// a stalled result keeps its value
	`BC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(coefficient))
	// one request at a time: ready drops after a transfer
	`BC_ASSERT_IMPL(a_one_at_a_time, clk, arst_n, in_valid && in_ready, ##1 !in_ready)
	// no result can appear in the cycle after a transfer
	`BC_ASSERT_NEXT(a_min_latency, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind binomial_coefficient binom_chk u_binom_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (operands.valid),
	.in_ready    (operands.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.coefficient (result.coefficient)
);
